// ===== src/ssad_pkg.sv =====
// Package for the sparse scatter-add block: payload structs, kind codes,
// store geometry and the binary32 adder stages. No dependencies.
package ssad_pkg;
    localparam int MaxRows = 64;
    localparam int MaxCols = 64;
    localparam int StoreDepth = MaxRows * MaxCols;
    localparam int AddrW = $clog2(StoreDepth);
    localparam int ColsW = 7;
    localparam logic [ColsW-1:0] ColsReset = 7'd64;
    localparam int QueueDepth = 2;
    localparam int QPtrW = $clog2(QueueDepth);
    localparam int QCntW = $clog2(QueueDepth + 1);

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_ACCUM = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [31:0] QNan = 32'h7FC00000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] element_value;
        logic        bad_address;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic             bad;
        logic [AddrW-1:0] addr;
        logic [31:0]      value;
    } t_cmd;

    // aligned operands after exponent compare and shift
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        s;
        logic        eff_sub;
        logic [8:0]  e;
        logic [26:0] ma;
        logic [26:0] mb;
    } t_align;

    function automatic t_align fadd_align(input logic [31:0] a, input logic [31:0] b);
        t_align o;
        logic [7:0] ea, eb, e1, e2;
        logic [22:0] fa, fb;
        logic sa, sb, s1, s2;
        logic [26:0] xa, xb, m1, m2, sh;
        logic [7:0] d;
        ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
        sa = a[31]; sb = b[31];
        o = '0;
        if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0)) begin
            o.special = 1'b1; o.special_val = QNan;
        end else if (ea == 8'hFF || eb == 8'hFF) begin
            o.special = 1'b1;
            if (ea == 8'hFF && eb == 8'hFF && sa != sb) o.special_val = QNan;
            else o.special_val = (ea == 8'hFF) ? a : b;
        end else if (a[30:0] == 0 && b[30:0] == 0) begin
            o.special = 1'b1; o.special_val = {sa & sb, 31'd0};
        end else if (b[30:0] == 0) begin
            o.special = 1'b1; o.special_val = a;
        end else if (a[30:0] == 0) begin
            o.special = 1'b1; o.special_val = b;
        end
        xa = {(ea != 0), fa, 3'b000};
        xb = {(eb != 0), fb, 3'b000};
        if (ea == 0) ea = 8'd1;
        if (eb == 0) eb = 8'd1;
        if (eb > ea || (eb == ea && xb > xa)) begin
            m1 = xb; m2 = xa; e1 = eb; e2 = ea; s1 = sb; s2 = sa;
        end else begin
            m1 = xa; m2 = xb; e1 = ea; e2 = eb; s1 = sa; s2 = sb;
        end
        d = e1 - e2;
        if (d >= 8'd27) sh = {26'd0, (m2 != 0)};
        else begin
            sh = m2 >> d;
            sh[0] = sh[0] | ((m2 & ((27'd1 << d) - 27'd1)) != 0);
        end
        o.s = s1; o.eff_sub = (s1 != s2); o.e = {1'b0, e1}; o.ma = m1; o.mb = sh;
        return o;
    endfunction

    function automatic logic [4:0] lzc27(input logic [27:0] m);
        logic [4:0] n;
        logic found;
        n = 5'd0; found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && m[i]) found = 1'b1;
            else if (!found) n = n + 5'd1;
        end
        return n;
    endfunction

    function automatic logic [31:0] fadd_finish(input t_align x);
        logic [27:0] m;
        logic [8:0] e;
        logic [4:0] lz, k;
        logic [24:0] r;
        logic [2:0] g;
        if (x.special) return x.special_val;
        e = x.e;
        if (!x.eff_sub) begin
            m = {1'b0, x.ma} + {1'b0, x.mb};
            if (m[27]) begin
                m = {1'b0, m[27:1]} | {27'd0, m[0]};
                e = e + 9'd1;
            end
        end else begin
            m = {1'b0, x.ma} - {1'b0, x.mb};
            if (m == 0) return 32'd0;
            lz = lzc27(m);
            k = (9'(lz) < e - 9'd1) ? lz : 5'(e - 9'd1);
            m = m << k;
            e = e - 9'(k);
        end
        r = {1'b0, m[26:3]};
        g = m[2:0];
        if (g > 3'd4 || (g == 3'd4 && r[0])) r = r + 25'd1;
        if (r[24]) begin
            r = r >> 1;
            e = e + 9'd1;
        end
        if (e >= 9'd255) return {x.s, 8'hFF, 23'd0};
        if (!r[23]) e = 9'd0;
        return {x.s, e[7:0], r[22:0]};
    endfunction
endpackage

// ===== src/ssad_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ssad_ram #(
    parameter int Width = 32,
    parameter int Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/ssad_front.sv =====
// Front end: accepts items, checks the column and forms the store address.
// Depends on ssad_pkg.
module ssad_front import ssad_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_data,
    input  logic [ColsW-1:0] i_cols,
    output logic             o_valid,
    input  logic             i_ready,
    output t_cmd             o_cmd
);
    t_cmd r_q [QueueDepth];
    logic [QPtrW-1:0] r_wp, r_rp;
    logic [QCntW-1:0] r_cnt;
    t_cmd n_cmd;
    logic [12:0] prod;
    logic push, pop;

    always_comb begin
        prod = 13'(i_data.row) * 13'(i_cols);
        prod = prod + 13'(i_data.col);
        n_cmd.kind = i_data.kind;
        n_cmd.value = i_data.value;
        n_cmd.addr = prod[AddrW-1:0];
        n_cmd.bad = ({1'b0, i_data.col} >= i_cols) || (prod >= 13'(StoreDepth));
    end

    assign o_ready = r_cnt != QCntW'(QueueDepth);
    assign push = i_valid && o_ready;
    assign o_valid = r_cnt != '0;
    assign pop = o_valid && i_ready;
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == QPtrW'(QueueDepth - 1)) ? '0 : r_wp + QPtrW'(1);
            if (pop) r_rp <= (r_rp == QPtrW'(QueueDepth - 1)) ? '0 : r_rp + QPtrW'(1);
            r_cnt <= r_cnt + QCntW'(push) - QCntW'(pop);
        end
        if (push) r_q[r_wp] <= n_cmd;
    end
endmodule

// ===== src/ssad_back.sv =====
// Back end: read, add and write back one command at a time, hold result.
// Depends on ssad_pkg and ssad_ram.
module ssad_back import ssad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_ALIGN = 4'b0100,
        S_ADD   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_cmd r_cmd;
    t_align r_al;
    logic [31:0] rdata, wdata;
    logic we, r_ovalid;
    t_out_item r_out;
    logic take, finish;
    t_out_item res;

    ssad_ram #(.Width(32), .Depth(StoreDepth)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_cmd.addr), .i_wdata(wdata),
        .i_raddr(i_cmd.addr), .o_rdata(rdata)
    );

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign take = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_data = r_out;

    always_comb begin
        n_state = r_state;
        finish = 1'b0;
        we = 1'b0;
        wdata = r_cmd.value;
        res.bad_address = 1'b0;
        res.element_value = rdata;
        case (r_state)
            S_IDLE: if (take) n_state = S_READ;
            S_READ: begin
                if (r_cmd.bad) begin
                    finish = 1'b1; res.bad_address = 1'b1; res.element_value = '0;
                    n_state = S_IDLE;
                end else if (r_cmd.kind == KIND_WRITE) begin
                    finish = 1'b1; we = 1'b1; res.element_value = r_cmd.value;
                    n_state = S_IDLE;
                end else if (r_cmd.kind == KIND_ACCUM) begin
                    n_state = S_ALIGN;
                end else begin
                    finish = 1'b1; n_state = S_IDLE;
                end
            end
            S_ALIGN: n_state = S_ADD;
            S_ADD: begin
                wdata = fadd_finish(r_al);
                we = 1'b1; finish = 1'b1; res.element_value = wdata;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
        if (take) r_cmd <= i_cmd;
        if (r_state == S_READ) r_al <= fadd_align(rdata, r_cmd.value);
        if (finish) r_out <= res;
    end
endmodule

// ===== src/sparse_scatter_add_into_dense.sv =====
// Sparse scatter-add into a dense binary32 matrix held in on-chip RAM.
// Input channel: i_valid/o_ready carrying i_data (kind, row, col, value).
// Output channel: o_valid/i_ready carrying o_data (element_value, bad_address).
// Config channel: i_cfg_valid/o_cfg_ready carrying i_cfg_data (cols_in_use).
// The front end computes row*cols_in_use+col and range-checks it, then
// queues the request in a two-entry queue. The back end handles one
// request at a time through the store (one write port, one read port):
// writes, reads and rejected requests finish in the read step, accumulates
// go on through align and add with write back. A new request enters the
// back end only once the previous result has been taken, so the back end
// never starts a request before it is through with the last one.
// While the receiver stalls, the result register holds and the queue
// fills; o_ready drops once it is full.
// Reset clears the queue and sets cols_in_use to 64; store contents are
// undefined until written.
// Depends on ssad_pkg, ssad_front, ssad_back.
module sparse_scatter_add_into_dense import ssad_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_item        o_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [ColsW-1:0] i_cfg_data
);
    logic [ColsW-1:0] r_cols;
    logic q_valid, q_ready;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cols <= ColsReset;
        else if (i_cfg_valid) r_cols <= i_cfg_data;
    end

    ssad_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .i_cols(r_cols), .o_valid(q_valid), .i_ready(q_ready),
        .o_cmd(q_cmd)
    );

    ssad_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_cmd(q_cmd), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );
endmodule
